@@ rtl/core/cbr_pkg.sv @@
// Shared types and constants for the color brightness rescale core.
package cbr_pkg;

  localparam int CH_W       = 8;
  localparam int PCT_W      = 7;
  localparam int K_W        = 15;
  localparam int NUM_W      = 23;
  localparam int DEN_W      = 15;
  localparam int Q_W        = 9;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = Q_W / DIV_BITS;
  localparam int NUM_CH     = 3;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [PCT_W-1:0]    PCT_RESET      = 7'd50;
  localparam logic [DEN_W-1:0]    PCT_SCALE      = 15'd100;
  localparam logic [CH_W-1:0]     FULL_SCALE     = 8'd255;
  localparam logic [APB_AW-3:0]   REG_BRIGHTNESS = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;
    logic [NUM_W-1:0]             dsh;
    logic [NUM_CH-1:0][Q_W-1:0]   quo;
  } div_t;

endpackage

@@ rtl/core/color_brightness_rescale_core.sv @@
// Throughput: one item per cycle while the output is not stalled; six register
// stages (max/scale, multiply, three divider stages of three quotient bits each,
// output register).
// A stalled output holds the pipeline; bubbles are absorbed stage by stage.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the
// brightness register to 50 percent.
module color_brightness_rescale_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cbr_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cbr_pkg::pix_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbr_pkg::APB_AW-1:0]    paddr,
  input  logic [cbr_pkg::APB_DW-1:0]    pwdata,
  output logic [cbr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // Each channel becomes floor(255 * pct * c / (100 * max)), saturated to 255.
  // A grey input gives floor(255 * pct / 100) from the same formula since c
  // equals max; only black needs its own path, where the numerator is
  // replaced by 255 * pct and the divisor by 100.

  // Configuration register.
  logic [cbr_pkg::PCT_W-1:0] pct_r;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[cbr_pkg::APB_AW-1:2] == cbr_pkg::REG_BRIGHTNESS);
  assign prdata  = reg_sel ? cbr_pkg::APB_DW'(pct_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= cbr_pkg::PCT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pct_r <= pwdata[cbr_pkg::PCT_W-1:0];
    end
  end

  // Handshake chain: each stage loads when it is empty or its successor
  // moves on in the same cycle.
  logic s1_rdy;
  logic s2_rdy;
  logic out_rdy;

  // Stage 1: largest channel and the scale factor 255 * pct.
  logic                      s1_valid_r;
  cbr_pkg::pix_in_t          s1_pix_r;
  logic [cbr_pkg::CH_W-1:0]  s1_hi_r;
  logic [cbr_pkg::K_W-1:0]   s1_k_r;
  logic [cbr_pkg::CH_W-1:0]  hi_nxt;
  logic [cbr_pkg::K_W-1:0]   k_nxt;

  always_comb begin
    hi_nxt = in_data.red_in;
    if (in_data.green_in > hi_nxt) begin
      hi_nxt = in_data.green_in;
    end
    if (in_data.blue_in > hi_nxt) begin
      hi_nxt = in_data.blue_in;
    end
    k_nxt = cbr_pkg::K_W'(pct_r) * cbr_pkg::K_W'(cbr_pkg::FULL_SCALE);
  end

  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_pix_r <= in_data;
      s1_hi_r  <= hi_nxt;
      s1_k_r   <= k_nxt;
    end
  end

  // Stage 2: numerators k * c and the divisor 100 * max, aligned to the
  // top quotient bit.
  logic                                     s2_valid_r;
  cbr_pkg::div_t                            s2_div_r;
  cbr_pkg::div_t                            div_nxt;
  logic [cbr_pkg::NUM_CH-1:0][cbr_pkg::CH_W-1:0] chan;
  logic [cbr_pkg::DEN_W-1:0]                den;
  logic                                     black;

  assign chan  = {s1_pix_r.blue_in, s1_pix_r.green_in, s1_pix_r.red_in};
  assign black = (s1_hi_r == '0);

  always_comb begin
    den = black ? cbr_pkg::PCT_SCALE
                : cbr_pkg::DEN_W'(s1_hi_r) * cbr_pkg::PCT_SCALE;
    div_nxt.dsh = cbr_pkg::NUM_W'({den, {(cbr_pkg::Q_W-1){1'b0}}});
    div_nxt.quo = '0;
    for (int c = 0; c < cbr_pkg::NUM_CH; c++) begin
      div_nxt.rem[c] = black ? cbr_pkg::NUM_W'(s1_k_r)
                             : cbr_pkg::NUM_W'(s1_k_r) * cbr_pkg::NUM_W'(chan[c]);
    end
  end

  // Divider pipeline.
  logic [cbr_pkg::DIV_STAGES:0] dv_valid;
  logic [cbr_pkg::DIV_STAGES:0] dv_ready;
  cbr_pkg::div_t                dv_data [cbr_pkg::DIV_STAGES+1];

  assign s2_rdy = !s2_valid_r || dv_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) begin
      s2_div_r <= div_nxt;
    end
  end

  assign dv_valid[0] = s2_valid_r;
  assign dv_data[0]  = s2_div_r;

  for (genvar i = 0; i < cbr_pkg::DIV_STAGES; i++) begin : g_div
    cbr_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[i]),
      .up_ready (dv_ready[i]),
      .up_data  (dv_data[i]),
      .dn_valid (dv_valid[i+1]),
      .dn_ready (dv_ready[i+1]),
      .dn_data  (dv_data[i+1])
    );
  end

  // Output register with saturation of quotients above full scale.
  logic              out_valid_r;
  cbr_pkg::pix_out_t out_data_r;
  cbr_pkg::pix_out_t out_nxt;
  logic [cbr_pkg::NUM_CH-1:0][cbr_pkg::CH_W-1:0] sat;

  always_comb begin
    for (int c = 0; c < cbr_pkg::NUM_CH; c++) begin
      if (dv_data[cbr_pkg::DIV_STAGES].quo[c][cbr_pkg::Q_W-1:cbr_pkg::CH_W] != '0) begin
        sat[c] = cbr_pkg::FULL_SCALE;
      end else begin
        sat[c] = dv_data[cbr_pkg::DIV_STAGES].quo[c][cbr_pkg::CH_W-1:0];
      end
    end
    out_nxt.red_out   = sat[0];
    out_nxt.green_out = sat[1];
    out_nxt.blue_out  = sat[2];
  end

  assign out_rdy                       = !out_valid_r || out_ready;
  assign dv_ready[cbr_pkg::DIV_STAGES] = out_rdy;
  assign out_valid                     = out_valid_r;
  assign out_data                      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_valid[cbr_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_valid[cbr_pkg::DIV_STAGES]) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

@@ rtl/core/cbr_div_stage.sv @@
// One registered stage of the three-channel restoring divider.
module cbr_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  cbr_pkg::div_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output cbr_pkg::div_t dn_data
);

  logic          valid_r;
  cbr_pkg::div_t data_r;
  cbr_pkg::div_t data_nxt;

  // Each step compares every remainder against the shifted divisor, then
  // moves the divisor one bit down for the next quotient bit.
  always_comb begin
    data_nxt = up_data;
    for (int j = 0; j < cbr_pkg::DIV_BITS; j++) begin
      for (int c = 0; c < cbr_pkg::NUM_CH; c++) begin
        if (data_nxt.rem[c] >= data_nxt.dsh) begin
          data_nxt.rem[c] = data_nxt.rem[c] - data_nxt.dsh;
          data_nxt.quo[c] = {data_nxt.quo[c][cbr_pkg::Q_W-2:0], 1'b1};
        end else begin
          data_nxt.quo[c] = {data_nxt.quo[c][cbr_pkg::Q_W-2:0], 1'b0};
        end
      end
      data_nxt.dsh = data_nxt.dsh >> 1;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/core/cbr_checker.sv @@
// Port-level checker for the color brightness rescale core and its bind.
module cbr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input cbr_pkg::pix_out_t          out_data,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [cbr_pkg::APB_AW-1:0] paddr,
  input logic [cbr_pkg::APB_DW-1:0] pwdata,
  input logic [cbr_pkg::APB_DW-1:0] prdata,
  input logic                       pready
);

  // A result that is not taken keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the output never stalled, an accepted item shows up at the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

  // A write to the brightness register reads back masked to seven bits.
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready
      && (paddr[cbr_pkg::APB_AW-1:2] == cbr_pkg::REG_BRIGHTNESS)
    |=> (paddr[cbr_pkg::APB_AW-1:2] != cbr_pkg::REG_BRIGHTNESS)
      || (prdata[cbr_pkg::PCT_W-1:0] == $past(pwdata[cbr_pkg::PCT_W-1:0])))
    else $error("brightness register readback mismatch");

endmodule

bind color_brightness_rescale_core cbr_checker u_cbr_checker (.*);
